// ===== hdl/ovl_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered value list package
// Beat types and request and status codes for the list core, and the value
// width that it shares with its entry store.
// ----------------------------------------------------------------------------
package ovl_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountFieldW = 5;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [ValueW-1:0] value;
  } ovl_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [CountFieldW-1:0] entry_count;
  } ovl_rsp_t;

endpackage

// ===== hdl/ovl_store.sv =====
// ----------------------------------------------------------------------------
// Ordered value list entry store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module ovl_store
  import ovl_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [ValueW-1:0] wr_data_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [ValueW-1:0] rd_data_o
);

  logic [ValueW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== hdl/ordered_value_list_core.sv =====
// ----------------------------------------------------------------------------
// Ordered value list core
// Bounded list of signed 32-bit values with insert, delete and search.
// ----------------------------------------------------------------------------
// A request beat on the input channel carries a kind and a value. Each request
// gives exactly one response beat with a status and the entry count after it.
// Insert appends at the tail and is rejected with a full status when the list
// holds CAPACITY entries. Delete removes the first equal entry and closes the
// gap. Search reports whether the value is held. An unused kind gives a
// not-found status and changes nothing.
// Insert, unused kinds and requests on an empty list answer in the cycle after
// the request beat. Search scans the held entries one per cycle until a match
// or the last entry. Delete scans up to the match and then moves every later
// entry down one slot, one per cycle, before it answers. The single read port
// of the entry store sets this pace.
// One request is in work at a time; the next request beat is taken once the
// core is idle and its response register is empty or being emptied.
// Reset empties the list at once; stale store contents are never used.
// While the receiver stalls, the response beat is held unchanged.
// ----------------------------------------------------------------------------
module ordered_value_list_core
  import ovl_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ovl_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ovl_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              is_del_q, is_del_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              out_valid_q, out_valid_d;
  ovl_rsp_t          out_rsp_q, out_rsp_d;

  logic              in_accept;
  logic              out_free;
  logic [CntW-1:0]   ptr_ext;
  logic              at_last;
  logic              hit;
  logic              give_rsp;
  logic [1:0]        rsp_status;

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [ValueW-1:0] wr_data;
  logic [IdxW-1:0]   rd_addr;
  logic [ValueW-1:0] rd_data;

  ovl_store #(
    .Depth (CAPACITY),
    .AddrW (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign ptr_ext = CntW'(ptr_q);
  assign at_last = ((ptr_ext + CntW'(1)) == count_q);
  assign hit     = (rd_data == val_q);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    is_del_d    = is_del_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    give_rsp    = 1'b0;
    rsp_status  = STATUS_MISSING;
    wr_en       = 1'b0;
    wr_addr     = ptr_q;
    wr_data     = rd_data;
    rd_addr     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          case (in_req_i.kind)
            KIND_INSERT: begin
              give_rsp = 1'b1;
              if (count_q == CntW'(CAPACITY)) begin
                rsp_status = STATUS_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = IdxW'(count_q);
                wr_data    = in_req_i.value;
                count_d    = count_q + CntW'(1);
                rsp_status = STATUS_DONE;
              end
            end
            KIND_DELETE, KIND_SEARCH: begin
              if (count_q == '0) begin
                give_rsp   = 1'b1;
                rsp_status = STATUS_MISSING;
              end else begin
                ptr_d    = '0;
                val_d    = in_req_i.value;
                is_del_d = (in_req_i.kind == KIND_DELETE);
                state_d  = StScan;
              end
            end
            default: begin
              give_rsp   = 1'b1;
              rsp_status = STATUS_MISSING;
            end
          endcase
        end
      end
      StScan: begin
        rd_addr = IdxW'(ptr_ext + CntW'(1));
        if (hit) begin
          if (is_del_q) begin
            state_d = StShift;
          end else begin
            give_rsp   = 1'b1;
            rsp_status = STATUS_DONE;
            state_d    = StIdle;
          end
        end else if (at_last) begin
          give_rsp   = 1'b1;
          rsp_status = STATUS_MISSING;
          state_d    = StIdle;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      StShift: begin
        rd_addr = IdxW'(ptr_ext + CntW'(2));
        if (at_last) begin
          count_d    = count_q - CntW'(1);
          give_rsp   = 1'b1;
          rsp_status = STATUS_DONE;
          state_d    = StIdle;
        end else begin
          wr_en   = 1'b1;
          wr_addr = ptr_q;
          wr_data = rd_data;
          ptr_d   = ptr_q + IdxW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (give_rsp) begin
      out_valid_d           = 1'b1;
      out_rsp_d.status      = rsp_status;
      out_rsp_d.entry_count = CountFieldW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      is_del_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      is_del_q    <= is_del_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_ptr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (ptr_ext < count_q))
    else $error("scan position beyond held entries");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_req_i.kind == KIND_INSERT && count_q != CntW'(CAPACITY))
      |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not add an entry");

  a_no_rsp_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !out_valid_q)
    else $error("response register busy during a scan");
`endif

endmodule
